// ===== rtl/lwsl_pkg.sv =====
// shared types and constants for the longest window sum block
package lwsl_pkg;

    // result field and channel widths
    localparam int BEST_W     = 13;
    localparam int M_TDATA_W  = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 2;

    // byte address of the sum limit register
    localparam logic [PADDR_W-1:0] SUM_LIMIT_ADDR = '0;

    // one transaction handed from the input register to the window core
    typedef struct packed {
        logic fire;
        logic last;
    } step_t;

endpackage

// ===== rtl/lwsl_cfg.sv =====
// configuration register file holding the window sum limit
module lwsl_cfg import lwsl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_DATA_W-1:0] sum_limit
);

    logic [CFG_DATA_W-1:0] sum_limit_reg;
    logic [CFG_DATA_W-1:0] sum_limit_next;
    logic                  wr_hit;

    // the only register sits at byte offset zero, other addresses are ignored
    assign wr_hit = psel && penable && pwrite && pready && (paddr == SUM_LIMIT_ADDR);

    always_comb begin
        sum_limit_next = sum_limit_reg;
        if (wr_hit) begin
            sum_limit_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_limit_reg <= '0;
        end else begin
            sum_limit_reg <= sum_limit_next;
        end
    end

    assign prdata    = sum_limit_reg;
    assign pready    = 1'b1;
    assign sum_limit = sum_limit_reg;

endmodule

// ===== rtl/lwsl_ram.sv =====
// generic ram: one write port, two registered read ports, read-first
module lwsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/lwsl_window.sv =====
// sliding window core: ring store, running sum, window length and best length
module lwsl_window import lwsl_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int VALUE_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  step_t                 step,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [CFG_DATA_W-1:0] sum_limit,
    output logic [BEST_W-1:0]     best_length
);

    localparam int PTR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = VALUE_BITS + LEN_W;
    localparam int CMP_W = (SUM_W > CFG_DATA_W) ? SUM_W : CFG_DATA_W;
    localparam int EXT_W = (LEN_W > BEST_W) ? LEN_W : BEST_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_ELEMENTS - 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_ELEMENTS);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [PTR_W-1:0]      op_reg, op_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      best_reg, best_next;

    // read port a address of the previous cycle, and the write of the previous cycle
    logic [PTR_W-1:0]      rd_addr_reg;
    logic                  wr_en_reg;
    logic [PTR_W-1:0]      wr_addr_reg;
    logic [VALUE_BITS-1:0] wr_data_reg;

    logic [VALUE_BITS-1:0] rdata_a, rdata_b;
    logic [VALUE_BITS-1:0] old_stored, old_value;
    logic [SUM_W-1:0]      sum_add;
    logic [CMP_W-1:0]      limit_ext;
    logic                  full, over, drop;
    logic [EXT_W-1:0]      best_ext;

    lwsl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_ring (
        .aclk    (aclk),
        .we      (step.fire),
        .waddr   (wp_reg),
        .wdata   (value),
        .raddr_a (op_reg),
        .raddr_b (ring_next(op_reg)),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb begin
        // oldest entry: forward the write of last cycle, else pick the port
        // that read the current oldest pointer
        if (wr_en_reg && wr_addr_reg == op_reg) begin
            old_stored = wr_data_reg;
        end else if (rd_addr_reg == op_reg) begin
            old_stored = rdata_a;
        end else begin
            old_stored = rdata_b;
        end
        // empty window: the new value is the oldest one
        old_value = (len_reg == '0) ? value : old_stored;

        limit_ext = CMP_W'(sum_limit);
        full      = (len_reg == LEN_FULL);
        sum_add   = sum_reg + SUM_W'(value);
        over      = CMP_W'(sum_add) > limit_ext;
        drop      = full || over;

        wp_next   = ring_next(wp_reg);
        op_next   = drop ? ring_next(op_reg) : op_reg;
        sum_next  = drop ? sum_add - SUM_W'(old_value) : sum_add;
        len_next  = drop ? len_reg : len_reg + LEN_W'(1);
        best_next = (len_next > best_reg) ? len_next : best_reg;

        best_ext    = EXT_W'(best_next);
        best_length = best_ext[BEST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            op_reg    <= '0;
            sum_reg   <= '0;
            len_reg   <= '0;
            best_reg  <= '0;
            wr_en_reg <= 1'b0;
        end else begin
            wr_en_reg <= step.fire;
            if (step.fire) begin
                if (step.last) begin
                    wp_reg   <= '0;
                    op_reg   <= '0;
                    sum_reg  <= '0;
                    len_reg  <= '0;
                    best_reg <= '0;
                end else begin
                    wp_reg   <= wp_next;
                    op_reg   <= op_next;
                    sum_reg  <= sum_next;
                    len_reg  <= len_next;
                    best_reg <= best_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= op_reg;
        wr_addr_reg <= wp_reg;
        wr_data_reg <= value;
    end

    a_len_no_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        step.fire && !step.last |=> len_reg >= $past(len_reg))
        else $error("window length decreased inside a set");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step.fire && step.last |=> len_reg == '0 && sum_reg == '0 && best_reg == '0)
        else $error("window state not cleared after last transaction");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_FULL && best_reg <= LEN_FULL)
        else $error("window length beyond ring depth");

    a_full_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg == LEN_FULL |-> wp_reg == op_reg)
        else $error("ring pointers apart while ring full");

endmodule

// ===== rtl/longest_window_sum_at_most_limit.sv =====
// Longest window sum at most limit: top level with input and result registers.
//
// Input channel s_*: one value per transaction, s_tlast marks the last value of a
// set. Result channel m_*: one transaction per set, carrying the longest run of
// consecutive values (at most MAX_ELEMENTS) whose sum stays within sum_limit.
// sum_limit is written over the APB-style port at byte address 0 (pready is
// always high) and keeps its value across sets; write it only while idle.
// Throughput: one value per cycle, unless a last value waits for a full output
// register. Each value waits in the input register, where an add, a compare, a
// subtract and one ring read settle the window; the result register loads, and
// m_tvalid rises, at the edge at which the last value leaves the input register.
// The ring store is a two-read-port ram, read ahead at the oldest pointer and
// its successor; no clearing pass is needed after reset.
// Reset (aresetn low, synchronous) clears the window, the pointers, sum_limit
// and both channel valid flags. A stalled receiver only holds back a last
// value: other values keep flowing while a result waits in the output register.
module longest_window_sum_at_most_limit import lwsl_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int VALUE_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: value [VALUE_BITS-1:0], zero padded to whole bytes
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                  s_tlast,
    // m_tdata: best_length [12:0], zero padded to 16 bits
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [M_TDATA_W-1:0]                  m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [PADDR_W-1:0]                    paddr,
    input  logic [CFG_DATA_W-1:0]                 pwdata,
    output logic [CFG_DATA_W-1:0]                 prdata,
    output logic                                  pready
);

    logic                  in_valid_reg, in_valid_next;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [BEST_W-1:0]     out_best_reg;
    logic [BEST_W-1:0]     best_length;
    logic [CFG_DATA_W-1:0] sum_limit;
    logic                  advance;
    step_t                 step;

    lwsl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sum_limit (sum_limit)
    );

    // a last value needs room in the output register, any other value moves on
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        step.fire = advance;
        step.last = in_last_reg;
    end

    lwsl_window #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .value       (in_value_reg),
        .sum_limit   (sum_limit),
        .best_length (best_length)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata[VALUE_BITS-1:0];
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_best_reg <= best_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_best_reg);

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the longest window sum at most limit block
`timescale 1ns / 1ps

// tracks the sliding window per accepted value and queues the best length of each set
class best_length_tracker_t;
    localparam int RING_DEPTH = 4096;

    logic [15:0] ring [RING_DEPTH];
    logic [11:0] head_ptr;
    logic [11:0] tail_ptr;
    logic [32:0] win_sum;
    logic [12:0] win_len;
    logic [12:0] best_len;
    logic [31:0] limit;
    logic [12:0] best_length_due [$];
    int          mismatches;

    function new();
        limit      = '0;
        mismatches = 0;
        clear_window();
    endfunction

    function void clear_window();
        head_ptr = '0;
        tail_ptr = '0;
        win_sum  = '0;
        win_len  = '0;
        best_len = '0;
    endfunction

    function void set_limit(logic [31:0] v);
        limit = v;
    endfunction

    function void take_value(logic [15:0] v, logic last);
        logic [15:0] oldest;
        if (win_len >= RING_DEPTH) begin
            // ring full: slide by one, length holds
            oldest   = ring[tail_ptr];
            tail_ptr = tail_ptr + 1'b1;
            win_sum  = win_sum - oldest + v;
            ring[head_ptr] = v;
            head_ptr = head_ptr + 1'b1;
        end else begin
            ring[head_ptr] = v;
            head_ptr = head_ptr + 1'b1;
            win_sum  = win_sum + v;
            win_len  = win_len + 1'b1;
            if (win_sum > {1'b0, limit}) begin
                oldest   = ring[tail_ptr];
                tail_ptr = tail_ptr + 1'b1;
                win_sum  = win_sum - oldest;
                win_len  = win_len - 1'b1;
            end
        end
        if (win_len > best_len)
            best_len = win_len;
        if (last) begin
            best_length_due.push_back(best_len);
            clear_window();
        end
    endfunction

    function void check_best_length(logic [12:0] got);
        logic [12:0] want;
        if (best_length_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: best_length %0d", got);
            return;
        end
        want = best_length_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("best_length mismatch: expected %0d, actual %0d", want, got);
        end
    endfunction

    function int pending();
        return best_length_due.size();
    endfunction
endclass

module testbench;
    import lwsl_pkg::*;

    localparam int  VALUE_BITS       = 16;
    localparam int  S_TDATA_W        = ((VALUE_BITS + 7) / 8) * 8;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  SETTLE_CYCLES    = 4;
    localparam int  CYCLE_LIMIT      = 1000000;
    localparam int  RANDOM_ITEMS     = 420;
    localparam int  QUIET_ITEMS      = 80;

    typedef enum int {VAL_SMALL, VAL_MID, VAL_FULL, VAL_CORNER} value_mix_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    best_length_tracker_t tracker = new();

    bit send_idle_on  = 1'b1;
    bit recv_idle_on  = 1'b1;
    bit long_hold_req = 1'b0;
    int cycle_count   = 0;
    int items_sent    = 0;

    longest_window_sum_at_most_limit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // accepted transactions on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.take_value(s_tdata[VALUE_BITS-1:0], s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_best_length(m_tdata[BEST_W-1:0]);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic write_limit(input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SUM_LIMIT_ADDR;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_limit(val);
    endtask

    task automatic send_value(input logic [15:0] v, input logic l);
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_value(value_mix_t mix);
        case (mix)
            VAL_SMALL: return 16'($urandom_range(0, 15));
            VAL_MID:   return 16'($urandom_range(0, 1023));
            VAL_FULL:  return 16'($urandom_range(0, 65535));
            default: begin
                case ($urandom_range(0, 2))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    default: return 16'($urandom_range(0, 65535));
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_limit(int phase);
        if (phase == 0)
            return 32'h0;
        if (phase == 1)
            return 32'hFFFF_FFFF;
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 40);
            1:       return $urandom_range(0, 5000);
            2:       return $urandom_range(0, 300000);
            3:       return $urandom();
            default: return $urandom_range(60000, 140000);
        endcase
    endfunction

    task automatic send_set(input int len, input value_mix_t mix);
        for (int i = 0; i < len; i++)
            send_value(pick_value(mix), i == len - 1);
    endtask

    // block is idle once every result is in and the pipeline has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int         phase;
        int         phase_items;
        int         len;
        value_mix_t mix;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // limit still at its reset value of zero
        send_value(16'd0, 1'b0);
        send_value(16'd0, 1'b0);
        send_value(16'd0, 1'b1);
        send_value(16'd5, 1'b1);
        drain();

        // lone value above the limit, then a sliding window
        write_limit(32'd100);
        send_value(16'd200, 1'b1);
        send_value(16'd30, 1'b0);
        send_value(16'd40, 1'b0);
        send_value(16'd50, 1'b0);
        send_value(16'd10, 1'b0);
        send_value(16'd20, 1'b1);
        drain();

        write_limit(32'hFFFF_FFFF);
        send_value(16'hFFFF, 1'b0);
        send_value(16'hFFFF, 1'b0);
        send_value(16'h0000, 1'b0);
        send_value(16'hFFFF, 1'b1);
        drain();

        write_limit(32'd65535);
        send_value(16'hFFFF, 1'b0);
        send_value(16'd1, 1'b0);
        send_value(16'hFFFF, 1'b0);
        send_value(16'd0, 1'b1);
        drain();

        write_limit(32'd1);
        send_value(16'd1, 1'b0);
        send_value(16'd0, 1'b0);
        send_value(16'd1, 1'b0);
        send_value(16'd1, 1'b1);
        drain();

        // set longer than the ring: fills it, then large values arrive while full
        write_limit(32'd409600);
        for (int i = 0; i < 4096; i++)
            send_value(16'($urandom_range(0, 100)), 1'b0);
        for (int i = 0; i < 50; i++)
            send_value(16'hFFFF, i == 49);
        drain();

        // receiver holds off while short sets keep coming, input backs up
        write_limit($urandom_range(0, 200000));
        send_idle_on  = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 15; i++)
            send_set($urandom_range(1, 3), VAL_FULL);
        send_idle_on = 1'b1;
        drain();

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            write_limit(pick_limit(phase));
            mix = value_mix_t'($urandom_range(0, 3));
            phase_items = 0;
            while (phase_items < 60) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                send_set(len, mix);
                phase_items += len;
            end
            drain();
            phase++;
        end

        // closing stretch with no stalls on either side
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_limit(pick_limit(phase));
        mix = value_mix_t'($urandom_range(0, 3));
        phase_items = 0;
        while (phase_items < QUIET_ITEMS) begin
            len = $urandom_range(1, 16);
            send_set(len, mix);
            phase_items += len;
        end
        drain();
        repeat (10) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/lwsl_pkg.sv
rtl/lwsl_cfg.sv
rtl/lwsl_ram.sv
rtl/lwsl_window.sv
rtl/longest_window_sum_at_most_limit.sv
tb/sv/testbench.sv
